>>> hw/rtl/mprx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mprx_pkg
// Shared constants, codes and lane structs for the multi-port receive capture.
// ----------------------------------------------------------------------------
package mprx_pkg;

  localparam int PORT_COUNT = 8;
  localparam int FIFO_DEPTH = 64;
  localparam int IDX_W      = $clog2(FIFO_DEPTH);
  localparam int BYTE_W     = 8;
  localparam int MASK_W     = 8;
  localparam int PORT_W     = 3;
  localparam int KIND_W     = 2;
  localparam int CNT_W      = $clog2(PORT_COUNT + 1);
  localparam int ROW_W      = 8 * BYTE_W;

  localparam logic [BYTE_W-1:0] COUNT_MAX   = 8'hFF;
  localparam logic [BYTE_W-1:0] DIV_RESET   = 8'd3;
  localparam logic [BYTE_W-1:0] TICK_RESET  = 8'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_DEQ   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef struct packed {
    logic store_req;
    logic pop_req;
    logic clr;
  } lane_cmd_t;

  typedef struct packed {
    logic drop;
    logic popped;
    logic avail;
  } lane_stat_t;

endpackage : mprx_pkg
`default_nettype wire

>>> hw/rtl/multi_port_rx_fifo_capture.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_port_rx_fifo_capture
// Eight-port receive capture: per-port ring FIFOs, sweep prescaler, drop count.
// ----------------------------------------------------------------------------
// Pipeline: an accepted word passes the s1 register, then the output register.
// Throughput: one word per cycle while out_ready is high; the s1 stage
//   is there for the registered read of each port's byte RAM.
// Reset: pointers, drop counter and valids clear at once; the prescaler loads
//   1 and the divider 3. No clearing pass; stored bytes are not reset.
// ----------------------------------------------------------------------------
module multi_port_rx_fifo_capture
  import mprx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [PORT_W-1:0] in_port,
  input  wire logic [MASK_W-1:0] in_ready_mask,
  input  wire logic [ROW_W-1:0]  in_rx_bytes,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_swept,
  output logic      [MASK_W-1:0] out_taken_mask,
  output logic      [BYTE_W-1:0] out_data,
  output logic                   out_data_valid,
  output logic      [MASK_W-1:0] out_available_mask,
  output logic      [BYTE_W-1:0] out_overflow_count,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [BYTE_W-1:0] cfg_data
);

  logic [BYTE_W-1:0] div_r, tick_r, tick_nxt, tick_dec;
  logic              acc, is_tick, is_deq, is_clr, sweep, out_free, s1_go;

  lane_cmd_t         cmd     [PORT_COUNT];
  lane_stat_t        stat    [PORT_COUNT];
  logic [BYTE_W-1:0] rd_byte [PORT_COUNT];

  logic [MASK_W-1:0] taken, avail_mask, popped;
  logic [BYTE_W-1:0] ovf_nxt, s1_data;

  logic              s1_valid_r, s1_swept_r, s1_dv_r;
  logic [PORT_W-1:0] s1_port_r;
  logic [MASK_W-1:0] s1_taken_r, s1_avail_r;
  logic [BYTE_W-1:0] s1_ovf_r;

  logic              out_valid_r, out_swept_r, out_dv_r;
  logic [MASK_W-1:0] out_taken_r, out_avail_r;
  logic [BYTE_W-1:0] out_data_r, out_ovf_r;

  assign out_free  = ~out_valid_r | out_ready;
  assign s1_go     = s1_valid_r & out_free;
  assign in_ready  = ~s1_valid_r | out_free;
  assign acc       = in_valid & in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    is_tick = 1'b0;
    is_deq  = 1'b0;
    is_clr  = 1'b0;
    case (kind_t'(in_kind))
      KIND_TICK:  is_tick = acc;
      KIND_DEQ:   is_deq  = acc;
      KIND_CLEAR: is_clr  = acc;
      default:    ;
    endcase
  end

  // sweep prescaler
  always_comb begin
    tick_dec = tick_r - 8'd1;
    sweep    = is_tick & (tick_dec == '0);
    if (!is_tick) begin
      tick_nxt = tick_r;
    end else if (sweep) begin
      tick_nxt = div_r;
    end else begin
      tick_nxt = tick_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r  <= DIV_RESET;
      tick_r <= TICK_RESET;
    end else begin
      tick_r <= tick_nxt;
      if (cfg_valid && cfg_ready) begin
        div_r <= cfg_data;
      end
    end
  end

  for (genvar p = 0; p < PORT_COUNT; p++) begin : g_lane
    always_comb begin
      cmd[p].store_req = sweep & in_ready_mask[p];
      cmd[p].pop_req   = is_deq & (in_port == PORT_W'(p));
      cmd[p].clr       = is_clr;
    end

    mprx_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd[p]),
      .wr_byte (in_rx_bytes[p*BYTE_W +: BYTE_W]),
      .stat    (stat[p]),
      .rd_byte (rd_byte[p])
    );
  end

  mprx_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (is_clr),
    .stat       (stat),
    .avail_mask (avail_mask),
    .ovf_nxt    (ovf_nxt)
  );

  always_comb begin
    taken  = '0;
    popped = '0;
    for (int p = 0; p < PORT_COUNT; p++) begin
      taken[p]  = cmd[p].store_req;
      popped[p] = stat[p].popped;
    end
  end

  // lane read data lands in the cycle after the pop
  always_comb begin
    s1_data = '0;
    for (int p = 0; p < PORT_COUNT; p++) begin
      if (s1_dv_r && s1_port_r == PORT_W'(p)) begin
        s1_data = rd_byte[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_swept_r <= sweep;
      s1_taken_r <= taken;
      s1_dv_r    <= |popped;
      s1_port_r  <= in_port;
      s1_avail_r <= avail_mask;
      s1_ovf_r   <= ovf_nxt;
    end
    if (s1_go) begin
      out_swept_r <= s1_swept_r;
      out_taken_r <= s1_taken_r;
      out_dv_r    <= s1_dv_r;
      out_data_r  <= s1_data;
      out_avail_r <= s1_avail_r;
      out_ovf_r   <= s1_ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_swept          = out_swept_r;
  assign out_taken_mask     = out_taken_r;
  assign out_data           = out_data_r;
  assign out_data_valid     = out_dv_r;
  assign out_available_mask = out_avail_r;
  assign out_overflow_count = out_ovf_r;

endmodule : multi_port_rx_fifo_capture
`default_nettype wire

>>> hw/rtl/mprx_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mprx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mprx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : mprx_ram
`default_nettype wire

>>> hw/rtl/mprx_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mprx_lane
// One port's ring FIFO: write/read pointers, one slot kept free, byte store.
// ----------------------------------------------------------------------------
module mprx_lane
  import mprx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lane_cmd_t         cmd,
  input  wire logic [BYTE_W-1:0] wr_byte,
  output lane_stat_t             stat,
  output logic      [BYTE_W-1:0] rd_byte
);

  logic [IDX_W-1:0] wr_r, wr_nxt;
  logic [IDX_W-1:0] rd_r, rd_nxt;
  logic [IDX_W-1:0] wr_inc, rd_inc;
  logic             full, empty, store, pop;

  always_comb begin
    wr_inc = (wr_r == IDX_W'(FIFO_DEPTH - 1)) ? '0 : wr_r + IDX_W'(1);
    rd_inc = (rd_r == IDX_W'(FIFO_DEPTH - 1)) ? '0 : rd_r + IDX_W'(1);
    full   = (wr_inc == rd_r);
    empty  = (wr_r == rd_r);
    store  = cmd.store_req & ~full;
    pop    = cmd.pop_req & ~empty;

    if (cmd.clr) begin
      wr_nxt = '0;
      rd_nxt = '0;
    end else begin
      wr_nxt = store ? wr_inc : wr_r;
      rd_nxt = pop ? rd_inc : rd_r;
    end

    stat.drop   = cmd.store_req & full;
    stat.popped = pop;
    stat.avail  = (wr_nxt != rd_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
    end
  end

  mprx_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (store),
    .waddr (wr_r),
    .wdata (wr_byte),
    .re    (pop),
    .raddr (rd_r),
    .rdata (rd_byte)
  );

endmodule : mprx_lane
`default_nettype wire

>>> hw/rtl/mprx_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mprx_merge
// Combines lane status: available mask and the saturating overflow counter.
// ----------------------------------------------------------------------------
module mprx_merge
  import mprx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              clr,
  input  wire lane_stat_t        stat [PORT_COUNT],
  output logic      [MASK_W-1:0] avail_mask,
  output logic      [BYTE_W-1:0] ovf_nxt
);

  logic [BYTE_W-1:0] ovf_r;
  logic [CNT_W-1:0]  drops;
  logic [BYTE_W:0]   sum;

  always_comb begin
    drops      = '0;
    avail_mask = '0;
    for (int p = 0; p < PORT_COUNT; p++) begin
      drops         = drops + CNT_W'(stat[p].drop);
      avail_mask[p] = stat[p].avail;
    end
    sum = {1'b0, ovf_r} + (BYTE_W + 1)'(drops);
    if (clr) begin
      ovf_nxt = '0;
    end else if (sum > {1'b0, COUNT_MAX}) begin
      ovf_nxt = COUNT_MAX;
    end else begin
      ovf_nxt = sum[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= '0;
    end else begin
      ovf_r <= ovf_nxt;
    end
  end

endmodule : mprx_merge
`default_nettype wire

>>> bench/rx_capture_checker.sv
// ----------------------------------------------------------------------------
// rx_capture_checker
// Tracks the eight capture FIFOs, the sweep prescaler and the drop counter
// from the accepted input and config words, and compares each result word.
// ----------------------------------------------------------------------------
module rx_capture_checker
  import mprx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [PORT_W-1:0] in_port,
  input  wire logic [MASK_W-1:0] in_ready_mask,
  input  wire logic [ROW_W-1:0]  in_rx_bytes,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic              out_swept,
  input  wire logic [MASK_W-1:0] out_taken_mask,
  input  wire logic [BYTE_W-1:0] out_data,
  input  wire logic              out_data_valid,
  input  wire logic [MASK_W-1:0] out_available_mask,
  input  wire logic [BYTE_W-1:0] out_overflow_count,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_ready,
  input  wire logic [BYTE_W-1:0] cfg_data,
  output int                     fail_count,
  output int                     pending,
  output int                     checked
);

  typedef struct packed {
    logic              swept;
    logic [MASK_W-1:0] taken_mask;
    logic [BYTE_W-1:0] data;
    logic              data_valid;
    logic [MASK_W-1:0] available_mask;
    logic [BYTE_W-1:0] overflow_count;
  } capture_word_t;

  logic [BYTE_W-1:0] slot_mem [PORT_COUNT][FIFO_DEPTH];
  logic [IDX_W-1:0]  wr_ptr [PORT_COUNT];
  logic [IDX_W-1:0]  rd_ptr [PORT_COUNT];
  logic [BYTE_W-1:0] drop_cnt;
  logic [BYTE_W-1:0] countdown;
  logic [BYTE_W-1:0] divider;

  capture_word_t expected_words [$];
  capture_word_t want;
  capture_word_t got;
  int errors    = 0;
  int n_checked = 0;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (int'(i) == FIFO_DEPTH - 1) ? '0 : i + 1'b1;
  endfunction

  function automatic void clear_fifos();
    for (int p = 0; p < PORT_COUNT; p++) begin
      wr_ptr[p] = '0;
      rd_ptr[p] = '0;
    end
    drop_cnt = '0;
  endfunction

  function automatic capture_word_t capture_step(input logic [KIND_W-1:0] kind,
                                                 input logic [PORT_W-1:0] port,
                                                 input logic [MASK_W-1:0] mask,
                                                 input logic [ROW_W-1:0]  bytes);
    capture_word_t    w;
    logic [IDX_W-1:0] nxt;
    w = '0;
    case (kind_t'(kind))
      KIND_TICK: begin
        countdown = countdown - 1'b1;
        if (countdown == '0) begin
          countdown = divider;
          w.swept = 1'b1;
          for (int p = 0; p < PORT_COUNT; p++) begin
            if (mask[p]) begin
              w.taken_mask[p] = 1'b1;
              nxt = next_idx(wr_ptr[p]);
              if (nxt == rd_ptr[p]) begin
                if (drop_cnt != COUNT_MAX) drop_cnt = drop_cnt + 1'b1;
              end else begin
                slot_mem[p][wr_ptr[p]] = bytes[BYTE_W*p +: BYTE_W];
                wr_ptr[p] = nxt;
              end
            end
          end
        end
      end
      KIND_DEQ: begin
        if (int'(port) < PORT_COUNT && wr_ptr[port] != rd_ptr[port]) begin
          w.data       = slot_mem[port][rd_ptr[port]];
          w.data_valid = 1'b1;
          rd_ptr[port] = next_idx(rd_ptr[port]);
        end
      end
      KIND_CLEAR: clear_fifos();
      default: ;
    endcase
    for (int p = 0; p < PORT_COUNT; p++) w.available_mask[p] = (wr_ptr[p] != rd_ptr[p]);
    w.overflow_count = drop_cnt;
    return w;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_fifos();
      countdown = TICK_RESET;
      divider   = DIV_RESET;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) divider = cfg_data;
      if (in_valid && in_ready) begin
        expected_words.push_back(capture_step(in_kind, in_port, in_ready_mask, in_rx_bytes));
      end
      if (out_valid && out_ready) begin
        got = '{out_swept, out_taken_mask, out_data, out_data_valid,
                out_available_mask, out_overflow_count};
        if (expected_words.size() == 0) begin
          $error("result word arrived with nothing expected");
          errors++;
        end else begin
          want = expected_words.pop_front();
          n_checked++;
          if (got.swept !== want.swept) begin
            $error("swept: expected %0d, got %0d", want.swept, got.swept);
            errors++;
          end
          if (got.taken_mask !== want.taken_mask) begin
            $error("taken_mask: expected %h, got %h", want.taken_mask, got.taken_mask);
            errors++;
          end
          if (got.data !== want.data) begin
            $error("data: expected %h, got %h", want.data, got.data);
            errors++;
          end
          if (got.data_valid !== want.data_valid) begin
            $error("data_valid: expected %0d, got %0d", want.data_valid, got.data_valid);
            errors++;
          end
          if (got.available_mask !== want.available_mask) begin
            $error("available_mask: expected %h, got %h",
                   want.available_mask, got.available_mask);
            errors++;
          end
          if (got.overflow_count !== want.overflow_count) begin
            $error("overflow_count: expected %0d, got %0d",
                   want.overflow_count, got.overflow_count);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_words.size();
    checked    <= n_checked;
  end

endmodule : rx_capture_checker

>>> bench/multi_port_rx_fifo_capture_test.sv
// ----------------------------------------------------------------------------
// multi_port_rx_fifo_capture_test
// Drives directed and random tick, dequeue and clear words into the capture
// block across several sweep divider settings and handshake idle patterns;
// the checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module multi_port_rx_fifo_capture_test;
  import mprx_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic [KIND_W-1:0] in_kind       = KIND_TICK;
  logic [PORT_W-1:0] in_port       = '0;
  logic [MASK_W-1:0] in_ready_mask = '0;
  logic [ROW_W-1:0]  in_rx_bytes   = '0;
  logic              out_ready     = 1'b0;
  logic              cfg_valid     = 1'b0;
  logic [BYTE_W-1:0] cfg_data      = '0;

  logic              in_ready;
  logic              out_valid;
  logic              out_swept;
  logic [MASK_W-1:0] out_taken_mask;
  logic [BYTE_W-1:0] out_data;
  logic              out_data_valid;
  logic [MASK_W-1:0] out_available_mask;
  logic [BYTE_W-1:0] out_overflow_count;
  logic              cfg_ready;

  int fail_count;
  int pending;
  int checked;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;
  int kind_seen [4] = '{default: 0};
  logic [BYTE_W-1:0] last_div;

  initial begin
    forever #5 clk = ~clk;
  end

  multi_port_rx_fifo_capture u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_port            (in_port),
    .in_ready_mask      (in_ready_mask),
    .in_rx_bytes        (in_rx_bytes),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_swept          (out_swept),
    .out_taken_mask     (out_taken_mask),
    .out_data           (out_data),
    .out_data_valid     (out_data_valid),
    .out_available_mask (out_available_mask),
    .out_overflow_count (out_overflow_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  rx_capture_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_port            (in_port),
    .in_ready_mask      (in_ready_mask),
    .in_rx_bytes        (in_rx_bytes),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_swept          (out_swept),
    .out_taken_mask     (out_taken_mask),
    .out_data           (out_data),
    .out_data_valid     (out_data_valid),
    .out_available_mask (out_available_mask),
    .out_overflow_count (out_overflow_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .pending            (pending),
    .checked            (checked)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("multi_port_rx_fifo_capture regression: fail");
      $finish;
    end
  end

  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [PORT_W-1:0] port,
                           input logic [MASK_W-1:0] mask, input logic [ROW_W-1:0] bytes);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_kind       <= kind;
    in_port       <= port;
    in_ready_mask <= mask;
    in_rx_bytes   <= bytes;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    kind_seen[kind]++;
  endtask

  // hold off until every expected word is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_divider(input logic [BYTE_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_word(input int deq_pct, input int clr_pct);
    int                roll;
    int                pick;
    logic [KIND_W-1:0] kind;
    logic [MASK_W-1:0] mask;
    roll = $urandom_range(99);
    pick = $urandom_range(9);
    if (roll < deq_pct) kind = KIND_DEQ;
    else if (roll < deq_pct + clr_pct) kind = KIND_CLEAR;
    else if (roll == 99) kind = KIND_NOP;
    else kind = KIND_TICK;
    if (pick < 4) mask = 8'hFF;
    else if (pick == 9) mask = 8'h00;
    else mask = MASK_W'($urandom);
    send_word(kind, PORT_W'($urandom_range(7)), mask, {$urandom, $urandom});
  endtask

  task automatic run_phase(input logic [BYTE_W-1:0] div, input int idle, input int stall,
                           input int words, input int deq_pct, input int clr_pct);
    settle();
    write_divider(div);
    idle_pct = idle;
    stall_pct <= stall;
    for (int i = 0; i < words; i++) begin
      if (i == words / 2) settle();
      random_word(deq_pct, clr_pct);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // first tick sweeps straight out of reset
    send_word(KIND_TICK, 3'd0, 8'hFF, 64'h0);
    send_word(KIND_TICK, 3'd7, 8'hFF, '1);
    send_word(KIND_TICK, 3'd0, 8'h00, '1);
    send_word(KIND_TICK, 3'd0, 8'hFF, '1);
    send_word(KIND_DEQ, 3'd0, 8'h00, 64'h0);
    send_word(KIND_DEQ, 3'd0, 8'h00, 64'h0);
    send_word(KIND_DEQ, 3'd0, 8'hFF, '1);
    send_word(KIND_DEQ, 3'd7, 8'hFF, 64'h0);
    send_word(KIND_NOP, 3'd3, 8'hFF, '1);
    send_word(KIND_CLEAR, 3'd0, 8'h00, 64'h0);
    send_word(KIND_DEQ, 3'd7, 8'h00, 64'h0);
    repeat (3) send_word(KIND_TICK, 3'd0, 8'hA5, 64'h0123_4567_89AB_CDEF);
    repeat (3) send_word(KIND_TICK, 3'd0, 8'h5A, 64'hFEDC_BA98_7654_3210);
    send_word(KIND_DEQ, 3'd0, 8'h00, 64'h0);
    send_word(KIND_DEQ, 3'd1, 8'h00, 64'h0);
    send_word(KIND_DEQ, 3'd5, 8'h00, 64'h0);

    run_phase(8'd1,   0,  0,  300, 15, 0);
    run_phase(8'd2,   77, 0,  300, 55, 2);
    run_phase(8'd0,   33, 33, 400, 20, 2);
    run_phase(8'd255, 0,  77, 250, 40, 2);
    last_div = BYTE_W'($urandom_range(6, 1));
    run_phase(last_div, 0, 0, 200, 35, 2);
    settle();

    if (pending != 0) $error("%0d expected words never arrived", pending);
    $display("summary: %0d words sent: %0d ticks, %0d dequeues, %0d clears, %0d unused kind",
             kind_seen.sum(), kind_seen[KIND_TICK], kind_seen[KIND_DEQ],
             kind_seen[KIND_CLEAR], kind_seen[KIND_NOP]);
    $display("summary: %0d result words compared; sweep dividers 3, 1, 2, 0, 255, %0d",
             checked, last_div);
    if (fail_count == 0 && pending == 0) begin
      $display("multi_port_rx_fifo_capture regression: pass");
    end else begin
      $display("multi_port_rx_fifo_capture regression: fail");
    end
    $finish;
  end

endmodule : multi_port_rx_fifo_capture_test
